### hw/rtl/sfla_pkg.sv
package sfla_pkg;

  localparam int SLOTS      = 256;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int OFF_W      = 21;
  localparam int SIZE_W     = 13;
  localparam int START_W    = 16;
  localparam int MAX_ITEM   = 4096;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
  localparam logic [1:0] STATUS_NOT_TAKEN = 2'd2;
  localparam logic [1:0] STATUS_RANGE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;

  typedef struct packed {
    logic             command;
    logic [OFF_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       slot_index;
    logic [OFF_W-1:0] slot_offset;
    logic [CNT_W-1:0] used_slots;
    logic             is_full;
    logic             is_empty;
  } rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
  } lnk_cmd_t;

endpackage

### hw/rtl/sfla_link_ram.sv
module sfla_link_ram (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [sfla_pkg::CNT_W-1:0]   node_count,
  input  sfla_pkg::lnk_cmd_t           cmd,
  output logic [sfla_pkg::LINK_W-1:0]  rd_data
);
  import sfla_pkg::*;

  logic [LINK_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]  valid;
  logic [LINK_W-1:0] mem_q;
  logic              valid_q;
  logic [SLOT_W-1:0] addr_q;
  logic [LINK_W-1:0] next_link;
  logic [LINK_W-1:0] init_link;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      mem_q  <= mem[cmd.rd_addr];
      addr_q <= cmd.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        valid_q <= valid[cmd.rd_addr];
      end
    end
  end

  // An entry never written since the chain was formed links to its successor.
  assign next_link = {1'b0, addr_q} + LINK_W'(1);
  assign init_link = (next_link < node_count) ? next_link : LINK_W'(SLOTS);
  assign rd_data   = valid_q ? mem_q : init_link;

endmodule

### hw/rtl/sfla_div.sv
module sfla_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sfla_pkg::OFF_W-1:0]  dividend,
  input  logic [sfla_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [sfla_pkg::OFF_W:0]    quotient
);
  import sfla_pkg::*;

  localparam int DIV_W     = OFF_W + 1;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [DIV_W-1:0]  work;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dvsr;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DIV_W-1:0]  work_next;
  logic [SIZE_W-1:0] rem_next;

  // Two restoring steps per cycle; quotient bits shift in as dividend bits shift out.
  always_comb begin
    logic [SIZE_W:0] sh;
    rem_next  = rem;
    work_next = work;
    for (int k = 0; k < 2; k++) begin
      sh        = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, dvsr}) begin
        sh           = sh - {1'b0, dvsr};
        work_next[0] = 1'b1;
      end
      rem_next = sh[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= {1'b0, dividend};
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

### hw/rtl/slab_free_list_allocator.sv
// Slot allocator for one slab of equal-sized slots kept on a linked free list.
// Request channel: req_valid, req_stall and req carry a command (allocate or
// free) and, for a free, the byte offset of the slot. Response channel:
// rsp_valid, rsp_stall and rsp carry exactly one result per request: status,
// slot index, slot byte offset, used slot count and full/empty flags.
// An allocate reads the link table on transfer, updates the free head and marks
// the slot taken in S_ALLOC, then loads the response register in S_DONE; with no
// slot free it goes straight to S_DONE. The next request is taken once the response
// is loaded. A free runs the two-bit-per-cycle offset divider in S_DIV, then one link
// table read, a write-back in S_FREE if the slot was taken, and one load of the
// response register. It skips the divider when the offset lies below data_start and
// skips the link table when the slot lies outside the slab. The link table is a single
// memory with a registered read port, and one request is worked on at a time.
// A new request is taken once the previous result sits in the response
// register, so a stalled receiver holds that result and at most one more
// request; the block then waits until the response register frees.
// Configuration is to be written through cfg_wr_en, cfg_index and cfg_data only
// while the block is idle; the block does not enforce this. Writing node_count
// re-forms the free chain at once. Reset sets node_count 256, slot size 16 bytes,
// data_start 1024 and an empty slab with all slots free; no clearing pass is needed.
module slab_free_list_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  sfla_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output sfla_pkg::rsp_t                    rsp,
  input  logic                              cfg_wr_en,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfla_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfla_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_ALLOC = 5'b00100,
    S_FREE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    node_count;
  logic [SIZE_W-1:0]   slot_bytes;
  logic [START_W-1:0]  data_start;
  logic [LINK_W-1:0]   free_head;
  logic [CNT_W-1:0]    used_count;
  logic [SLOT_W-1:0]   idx;
  logic [1:0]          res_status;
  logic [7:0]          res_index;
  logic [OFF_W-1:0]    res_offset;

  logic                accept;
  logic                below;
  logic [OFF_W-1:0]    diff;
  logic                head_ok;
  logic                div_start;
  logic                div_done;
  logic [OFF_W:0]      div_quo;
  logic                quo_ok;
  logic                free_ok;
  logic [LINK_W-1:0]   lnk_rd;
  lnk_cmd_t            lnk_cmd;
  logic [OFF_W-1:0]    prod;
  logic [OFF_W-1:0]    base;
  logic                rsp_load;
  logic                chain_reset;
  logic [CNT_W-1:0]    cfg_nodes;
  logic [SIZE_W-1:0]   cfg_size;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign below     = req.free_offset < OFF_W'(data_start);
  assign diff      = req.free_offset - OFF_W'(data_start);
  assign head_ok   = free_head < node_count;
  assign div_start = accept && (req.command == CMD_FREE) && !below;
  assign quo_ok    = div_quo < (OFF_W + 1)'(node_count);
  assign free_ok   = (lnk_rd == {1'b0, idx}) && (used_count != '0);
  assign prod      = {{(OFF_W-SIZE_W){1'b0}}, slot_bytes} * {{(OFF_W-SLOT_W){1'b0}}, idx};
  assign base      = OFF_W'(data_start) + prod;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  assign chain_reset = cfg_wr_en && (cfg_index == CFG_NODE_COUNT);

  always_comb begin
    if (cfg_data[CNT_W-1:0] == '0) begin
      cfg_nodes = CNT_W'(1);
    end else if (cfg_data[CNT_W-1:0] > CNT_W'(SLOTS)) begin
      cfg_nodes = CNT_W'(SLOTS);
    end else begin
      cfg_nodes = cfg_data[CNT_W-1:0];
    end
    if (cfg_data[SIZE_W-1:0] == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (cfg_data[SIZE_W-1:0] > SIZE_W'(MAX_ITEM)) begin
      cfg_size = SIZE_W'(MAX_ITEM);
    end else begin
      cfg_size = cfg_data[SIZE_W-1:0];
    end
  end

  always_comb begin
    lnk_cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && (req.command == CMD_ALLOC) && head_ok) begin
          lnk_cmd.rd_en   = 1'b1;
          lnk_cmd.rd_addr = free_head[SLOT_W-1:0];
        end
      end
      S_DIV: begin
        if (div_done && quo_ok) begin
          lnk_cmd.rd_en   = 1'b1;
          lnk_cmd.rd_addr = div_quo[SLOT_W-1:0];
        end
      end
      S_ALLOC: begin
        lnk_cmd.wr_en   = 1'b1;
        lnk_cmd.wr_addr = idx;
        lnk_cmd.wr_data = {1'b0, idx};
      end
      S_FREE: begin
        if (free_ok) begin
          lnk_cmd.wr_en   = 1'b1;
          lnk_cmd.wr_addr = idx;
          lnk_cmd.wr_data = free_head;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  sfla_link_ram u_link_ram (
    .clk        (clk),
    .rst        (rst),
    .clear      (chain_reset),
    .node_count (node_count),
    .cmd        (lnk_cmd),
    .rd_data    (lnk_rd)
  );

  sfla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (slot_bytes),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= CNT_W'(SLOTS);
      slot_bytes <= SIZE_W'(16);
      data_start <= START_W'(1024);
      free_head  <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: begin
            node_count <= cfg_nodes;
            free_head  <= '0;
            used_count <= '0;
          end
          CFG_SLOT_BYTES: begin
            slot_bytes <= cfg_size;
          end
          CFG_DATA_START: begin
            data_start <= cfg_data[START_W-1:0];
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.command == CMD_ALLOC) begin
              state <= head_ok ? S_ALLOC : S_DONE;
            end else begin
              state <= below ? S_DONE : S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= quo_ok ? S_FREE : S_DONE;
          end
        end
        S_ALLOC: begin
          free_head  <= lnk_rd;
          used_count <= used_count + CNT_W'(1);
          state      <= S_DONE;
        end
        S_FREE: begin
          if (free_ok) begin
            free_head  <= {1'b0, idx};
            used_count <= used_count - CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx        <= free_head[SLOT_W-1:0];
          res_index  <= '0;
          res_offset <= '0;
          res_status <= (req.command == CMD_ALLOC) ? STATUS_NO_SLOT : STATUS_RANGE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx <= div_quo[SLOT_W-1:0];
        end
      end
      S_ALLOC: begin
        res_status <= STATUS_OK;
        res_index  <= 8'(idx);
        res_offset <= base;
      end
      S_FREE: begin
        res_status <= free_ok ? STATUS_OK : STATUS_NOT_TAKEN;
        res_index  <= 8'(idx);
        res_offset <= base;
      end
      S_DONE: begin
        if (rsp_load) begin
          rsp.status      <= res_status;
          rsp.slot_index  <= res_index;
          rsp.slot_offset <= res_offset;
          rsp.used_slots  <= used_count;
          rsp.is_full     <= (used_count == node_count);
          rsp.is_empty    <= (used_count == '0);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

class slot_ledger;
  logic [8:0] links [256];
  int unsigned head;
  int unsigned used;
  int unsigned nodes;
  int unsigned size;
  int unsigned start;
  sfla_pkg::rsp_t awaited [$];
  int unsigned mismatches;

  function new();
    nodes = 256;
    size = 16;
    start = 1024;
    mismatches = 0;
    reform();
  endfunction

  // Writing the slot count puts every slot back on the free chain in order.
  function void reform();
    for (int i = 0; i < sfla_pkg::SLOTS; i++) begin
      links[i] = (i + 1 < nodes) ? 9'(i + 1) : 9'(sfla_pkg::SLOTS);
    end
    head = 0;
    used = 0;
  endfunction

  function void set_register(logic [1:0] idx, int unsigned val);
    int unsigned v;
    if (idx == sfla_pkg::CFG_NODE_COUNT) begin
      v = val & 32'h1FF;
      nodes = (v == 0) ? 1 : (v > sfla_pkg::SLOTS) ? sfla_pkg::SLOTS : v;
      reform();
    end else if (idx == sfla_pkg::CFG_SLOT_BYTES) begin
      v = val & 32'h1FFF;
      size = (v == 0) ? 1 : (v > sfla_pkg::MAX_ITEM) ? sfla_pkg::MAX_ITEM : v;
    end else if (idx == sfla_pkg::CFG_DATA_START) begin
      start = val & 32'hFFFF;
    end
  endfunction

  function void note_request(sfla_pkg::req_t r);
    sfla_pkg::rsp_t e;
    logic [1:0] st;
    int unsigned off;
    int unsigned q;
    int unsigned idx;
    int unsigned base;
    st = sfla_pkg::STATUS_OK;
    idx = 0;
    base = 0;
    if (r.command == sfla_pkg::CMD_ALLOC) begin
      if (head >= nodes || head >= sfla_pkg::SLOTS) begin
        st = sfla_pkg::STATUS_NO_SLOT;
      end else begin
        idx = head;
        head = links[idx];
        links[idx] = 9'(idx);
        used++;
        base = start + size * idx;
      end
    end else begin
      off = r.free_offset;
      if (off < start) begin
        st = sfla_pkg::STATUS_RANGE;
      end else begin
        q = (off - start) / size;
        if (q >= nodes || q >= sfla_pkg::SLOTS) begin
          st = sfla_pkg::STATUS_RANGE;
        end else begin
          idx = q;
          base = start + size * idx;
          if (links[idx] != idx || used == 0) begin
            st = sfla_pkg::STATUS_NOT_TAKEN;
          end else begin
            links[idx] = 9'(head);
            head = idx;
            used--;
          end
        end
      end
    end
    e.status = st;
    e.slot_index = 8'(idx);
    e.slot_offset = 21'(base);
    e.used_slots = 9'(used);
    e.is_full = (used == nodes);
    e.is_empty = (used == 0);
    awaited.push_back(e);
  endfunction

  function void check_response(sfla_pkg::rsp_t got);
    sfla_pkg::rsp_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("tb: response with nothing outstanding: st=%0d idx=%0d off=%0d used=%0d",
                 got.status, got.slot_index, got.slot_offset, got.used_slots);
      end
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status || got.slot_index !== want.slot_index ||
        got.slot_offset !== want.slot_offset || got.used_slots !== want.used_slots ||
        got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("tb: mismatch expected st=%0d idx=%0d off=%0d used=%0d full=%0b empty=%0b",
                 want.status, want.slot_index, want.slot_offset, want.used_slots,
                 want.is_full, want.is_empty);
        $display("tb:          actual   st=%0d idx=%0d off=%0d used=%0d full=%0b empty=%0b",
                 got.status, got.slot_index, got.slot_offset, got.used_slots,
                 got.is_full, got.is_empty);
      end
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb;
  import sfla_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slot_ledger ledger;
  int snd_max;
  int rcv_max;
  int hold_len;
  int quiet_cycles;

  slab_free_list_allocator dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic req_t mk(logic c, int unsigned off);
    req_t r;
    r.command = c;
    r.free_offset = 21'(off);
    return r;
  endfunction

  function automatic req_t pick_item(int alloc_pct);
    req_t r;
    int roll;
    int unsigned idx;
    int unsigned taken [$];
    r = mk(CMD_ALLOC, $urandom);
    if ($urandom_range(99) < alloc_pct) return r;
    r.command = CMD_FREE;
    for (int i = 0; i < ledger.nodes; i++) begin
      if (ledger.links[i] == i) taken.push_back(i);
    end
    roll = $urandom_range(99);
    if (roll < 75 && taken.size() > 0) begin
      idx = taken[$urandom_range(taken.size() - 1)];
      r.free_offset = 21'(ledger.start + ledger.size * idx +
                          ($urandom_range(1) ? 0 : $urandom_range(ledger.size - 1)));
    end else if (roll < 85) begin
      idx = $urandom_range(ledger.nodes - 1);
      r.free_offset = 21'(ledger.start + ledger.size * idx + $urandom_range(ledger.size - 1));
    end else if (roll < 91 && ledger.start > 0) begin
      r.free_offset = 21'($urandom_range(ledger.start - 1));
    end else if (roll < 96) begin
      r.free_offset = 21'(ledger.start + ledger.size * ledger.nodes + $urandom_range(5000));
    end else begin
      r.free_offset = 21'($urandom);
    end
    return r;
  endfunction

  task automatic send(req_t r);
    int gap;
    gap = $urandom_range(0, snd_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    ledger.note_request(r);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    ledger.set_register(idx, val);
  endtask

  task automatic program_slab(bit do_nodes, int unsigned nc, int unsigned isz, int unsigned ds);
    if (do_nodes) put_reg(CFG_NODE_COUNT, nc);
    put_reg(CFG_SLOT_BYTES, isz);
    put_reg(CFG_DATA_START, ds);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(bit do_nodes, int unsigned nc, int unsigned isz, int unsigned ds,
                           int n, int pct, int smax, int rmax, int hold);
    settle();
    program_slab(do_nodes, nc, isz, ds);
    snd_max = smax;
    rcv_max = rmax;
    hold_len = hold;
    for (int k = 0; k < n; k++) begin
      send(pick_item(k < n / 2 ? pct : 100 - pct));
    end
  endtask

  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      if (hold_len > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        n = $urandom_range(0, rcv_max);
        if (n > 0) begin
          rsp_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) ledger.check_response(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ledger = new();
    snd_max = 11;
    rcv_max = 11;
    hold_len = 0;
    quiet_cycles = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send(mk(CMD_ALLOC, 32'h1FFFFF));
    send(mk(CMD_ALLOC, 0));
    send(mk(CMD_FREE, 1024 + 16 + 15));
    send(mk(CMD_FREE, 1024 + 16));
    send(mk(CMD_FREE, 1023));
    send(mk(CMD_FREE, 1024 + 16 * 256));
    send(mk(CMD_FREE, 32'h1FFFFF));
    send(mk(CMD_FREE, 1024));
    send(mk(CMD_FREE, 1024));

    settle();
    program_slab(1'b1, 1, 8191, 65535);
    send(mk(CMD_ALLOC, 0));
    send(mk(CMD_ALLOC, 0));
    send(mk(CMD_FREE, 65535 + 4095));
    send(mk(CMD_FREE, 65535 + 4096));
    send(mk(CMD_FREE, 0));

    settle();
    program_slab(1'b1, 0, 0, 0);
    send(mk(CMD_FREE, 0));
    send(mk(CMD_ALLOC, 0));
    send(mk(CMD_ALLOC, 0));
    send(mk(CMD_FREE, 0));
    send(mk(CMD_FREE, 1));

    settle();
    program_slab(1'b1, 511, 4096, 0);
    send(mk(CMD_ALLOC, 0));
    send(mk(CMD_FREE, 4096 * 255));
    send(mk(CMD_ALLOC, 0));
    send(mk(CMD_FREE, 4096 * 256));

    run_phase(1'b1, 5, 3, 0, 120, 60, 11, 11, 0);
    run_phase(1'b1, 256, 4096, 65535, 400, 85, 11, 11, 0);
    run_phase(1'b1, 0, 0, 7, 80, 60, 0, 0, 300);
    run_phase(1'b1, 511, 8191, 300, 250, 75, 6, 11, 0);
    run_phase(1'b0, 0, 1000, 12345, 200, 50, 3, 11, 0);
    run_phase(1'b1, 37, 13, 500, 200, 70, 11, 0, 0);

    req_valid <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/sfla_pkg.sv
hw/rtl/sfla_link_ram.sv
hw/rtl/sfla_div.sv
hw/rtl/slab_free_list_allocator.sv
test/tb.sv
